### src/tile_value_dictionary_encoder_defines.svh
// Assertion macros shared by the tile value dictionary encoder checkers.
// Depends on signals clk and arst_n in the scope of each use.
`ifndef TILE_VALUE_DICTIONARY_ENCODER_DEFINES_SVH
`define TILE_VALUE_DICTIONARY_ENCODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TVDE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define TVDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tvde_pkg.sv
// Shared types, constants and helpers for the tile value dictionary encoder.
// No dependencies.
package tvde_pkg;

	localparam int VAL_W  = 16;
	localparam int BITS_W = 5;
	localparam int IDX_W  = 2;

	typedef enum logic [1:0] {
		OP_RAW   = 2'd0,
		OP_DELTA = 2'd1,
		OP_T0    = 2'd2,
		OP_T1    = 2'd3
	} op_code_t;

	localparam logic [IDX_W-1:0] REG_T0_BASE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_T1_BASE  = 2'd1;
	localparam logic [IDX_W-1:0] REG_T1_LIMIT = 2'd2;

	localparam logic [VAL_W-1:0] T0_BASE_RST  = 16'h0000;
	localparam logic [VAL_W-1:0] T1_BASE_RST  = 16'h0000;
	localparam logic [VAL_W-1:0] T1_LIMIT_RST = 16'hFFFF;

	typedef struct packed {
		op_code_t          op;
		logic [VAL_W-1:0]  payload;
		logic [BITS_W-1:0] nbits;
		logic              unreach;
	} tvde_result_t;

	typedef struct packed {
		logic inc_t0;
		logic inc_t1;
	} tvde_upd_t;

	// Position of the highest set bit plus one, zero for zero.
	function automatic logic [BITS_W-1:0] bit_len(input logic [VAL_W-1:0] v);
		logic [BITS_W-1:0] n;
		n = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (v[i]) begin
				n = BITS_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

### src/tvde_regs.sv
// Configuration registers and the two running reference tiles.
// Depends on tvde_pkg.
module tvde_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tvde_pkg::IDX_W-1:0] cfg_index,
	input  logic [tvde_pkg::VAL_W-1:0] cfg_data,
	input  logic                      step,
	input  tvde_pkg::tvde_upd_t       upd,
	output logic [tvde_pkg::VAL_W-1:0] t0_cur,
	output logic [tvde_pkg::VAL_W-1:0] t1_cur,
	output logic [tvde_pkg::VAL_W-1:0] t1_base,
	output logic [tvde_pkg::VAL_W-1:0] t1_limit
);
	import tvde_pkg::*;

	logic [VAL_W-1:0] t0_cur_q, t1_cur_q, t1_base_q, t1_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t0_cur_q   <= T0_BASE_RST;
			t1_cur_q   <= T1_BASE_RST;
			t1_base_q  <= T1_BASE_RST;
			t1_limit_q <= T1_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_T0_BASE: begin
					t0_cur_q <= cfg_data;
				end
				REG_T1_BASE: begin
					t1_base_q <= cfg_data;
					t1_cur_q  <= cfg_data;
				end
				REG_T1_LIMIT: begin
					t1_limit_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end else if (step) begin
			if (upd.inc_t0) begin
				t0_cur_q <= t0_cur_q + VAL_W'(1);
			end
			if (upd.inc_t1) begin
				t1_cur_q <= t1_cur_q + VAL_W'(1);
			end
		end
	end

	assign t0_cur   = t0_cur_q;
	assign t1_cur   = t1_cur_q;
	assign t1_base  = t1_base_q;
	assign t1_limit = t1_limit_q;

endmodule

### src/tvde_encode.sv
// Operand code selection for one tile value against the current references.
// Depends on tvde_pkg.
module tvde_encode (
	input  logic [tvde_pkg::VAL_W-1:0] value,
	input  logic [tvde_pkg::VAL_W-1:0] t0_cur,
	input  logic [tvde_pkg::VAL_W-1:0] t1_cur,
	input  logic [tvde_pkg::VAL_W-1:0] t1_base,
	input  logic [tvde_pkg::VAL_W-1:0] t1_limit,
	output tvde_pkg::tvde_result_t    res,
	output tvde_pkg::tvde_upd_t       upd
);
	import tvde_pkg::*;

	logic              hit_t1, hit_t0, delta_ok;
	logic [VAL_W-1:0]  t1_gap, diff, maxv;
	logic [VAL_W:0]    span;
	logic [BITS_W-1:0] dist_bits, t0_bits;

	always_comb begin
		hit_t1    = (value == t1_cur) && (t1_cur < t1_limit);
		hit_t0    = (value == t0_cur);
		t1_gap    = t1_cur - t1_base;
		dist_bits = bit_len(t1_gap);
		span      = ((VAL_W+1)'(1) << dist_bits) - (VAL_W+1)'(1);
		maxv      = span[VAL_W-1:0];
		diff      = value - t1_base;
		delta_ok  = (value >= t1_base) && (diff <= maxv);
		t0_bits   = bit_len(t0_cur);

		res = '{op: OP_RAW, payload: '0, nbits: '0, unreach: 1'b0};
		upd = '{inc_t0: 1'b0, inc_t1: 1'b0};
		priority if (hit_t1) begin
			res.op     = OP_T1;
			upd.inc_t1 = 1'b1;
		end else if (hit_t0) begin
			res.op     = OP_T0;
			upd.inc_t0 = 1'b1;
		end else if (delta_ok) begin
			res.op      = OP_DELTA;
			res.payload = diff;
			res.nbits   = dist_bits;
		end else if (bit_len(value) > t0_bits) begin
			res.unreach = 1'b1;
		end else begin
			res.payload = value;
			res.nbits   = t0_bits;
		end
	end

endmodule

### src/tile_value_dictionary_encoder.sv
// Top level of the tile value dictionary encoder.
// Depends on tvde_pkg, tvde_regs and tvde_encode.

// Encodes one 16-bit tile value per transaction into a 2-bit operand code plus
// payload bits, against two running reference tiles T0 and T1. The block takes
// one transaction every clock cycle while in_stall is low: the value lands in an
// input register, is coded by a single level of compare/subtract/leading-one
// logic, and the outcome lands in the result register. The reference update
// happens in the same cycle as the coding, so the loop through T0/T1 allows one
// item per cycle. While the result waits under out_stall, the input register
// still takes one more transaction; in_stall rises only when both registers
// are full. Configuration writes take effect at once; writing t0_base or
// t1_base also reloads the matching reference. Write configuration only while
// the pipeline is empty.
module tile_value_dictionary_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tvde_pkg::VAL_W-1:0]  tile_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  op_code,
	output logic [tvde_pkg::VAL_W-1:0]  payload,
	output logic [tvde_pkg::BITS_W-1:0] payload_bits,
	output logic                        unreachable,
	input  logic                        cfg_we,
	input  logic [tvde_pkg::IDX_W-1:0]  cfg_index,
	input  logic [tvde_pkg::VAL_W-1:0]  cfg_data
);
	import tvde_pkg::*;

	// Input register (stage 1) and result register (stage 2).
	logic             vld_s1, vld_s2;
	logic [VAL_W-1:0] tile_s1;
	tvde_result_t     res_s2;

	logic             take_s2, move_s1, take_s1;
	logic [VAL_W-1:0] t0_cur, t1_cur, t1_base, t1_limit;
	tvde_result_t     res;
	tvde_upd_t        upd;

	// Result register frees when empty or when its transaction leaves.
	assign take_s2  = !vld_s2 || !out_stall;
	// Advance the coded item into the result register; this is also the
	// moment the references step.
	assign move_s1  = vld_s1 && take_s2;
	assign in_stall = vld_s1 && !take_s2;
	assign take_s1  = in_valid && !in_stall;

	tvde_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (move_s1),
		.upd      (upd),
		.t0_cur   (t0_cur),
		.t1_cur   (t1_cur),
		.t1_base  (t1_base),
		.t1_limit (t1_limit)
	);

	tvde_encode u_encode (
		.value   (tile_s1),
		.t0_cur  (t0_cur),
		.t1_cur  (t1_cur),
		.t1_base (t1_base),
		.t1_limit(t1_limit),
		.res     (res),
		.upd     (upd)
	);

	// Hold the input register while the result side is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take_s1) begin
			vld_s1 <= 1'b1;
		end else if (move_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			tile_s1 <= tile_value;
		end
	end

	// Load a fresh result or drop the delivered one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (take_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = vld_s2;
	assign op_code      = res_s2.op;
	assign payload      = res_s2.payload;
	assign payload_bits = res_s2.nbits;
	assign unreachable  = res_s2.unreach;

endmodule

### src/tvde_checker.sv
// Port-level checker for the tile value dictionary encoder, with its bind.
// Depends on tvde_pkg and tile_value_dictionary_encoder_defines.svh.
`include "tile_value_dictionary_encoder_defines.svh"

module tvde_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  op_code,
	input logic [tvde_pkg::VAL_W-1:0]  payload,
	input logic [tvde_pkg::BITS_W-1:0] payload_bits,
	input logic                        unreachable
);
	import tvde_pkg::*;

	`TVDE_ASSERT(a_unreach_empty, !(out_valid && unreachable) || (op_code == OP_RAW && payload == '0 && payload_bits == '0), "unreachable result carries code or payload")

	`TVDE_ASSERT(a_match_empty, !(out_valid && (op_code == OP_T0 || op_code == OP_T1)) || (payload == '0 && payload_bits == '0 && !unreachable), "match code carries payload")

	`TVDE_ASSERT(a_payload_fits, !out_valid || (payload_bits <= BITS_W'(VAL_W) && (payload >> payload_bits) == '0), "payload wider than its bit count")

	`TVDE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(op_code) && $stable(payload) && $stable(payload_bits) && $stable(unreachable), "stalled result changed")

endmodule

bind tile_value_dictionary_encoder tvde_checker u_tvde_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.op_code     (op_code),
	.payload     (payload),
	.payload_bits(payload_bits),
	.unreachable (unreachable)
);

### tb/tb_tile_value_dictionary_encoder.sv
// Self-checking testbench for the tile value dictionary encoder.
// Depends on tvde_pkg and tile_value_dictionary_encoder; a scoreboard class predicts each code.
`timescale 1ns / 1ps

module tb_tile_value_dictionary_encoder;
	import tvde_pkg::*;

	// Index with no register behind it; writes there must change nothing.
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 100;

	// One predicted result, tagged with the tile that caused it.
	typedef struct {
		logic [VAL_W-1:0] tile;
		tvde_result_t     code;
	} coded_tile_t;

	// Tracks the two running references and the registers, predicts the
	// code for every accepted tile and checks results in order.
	class tile_code_scoreboard;
		logic [VAL_W-1:0] t0_base_q;
		logic [VAL_W-1:0] t1_base_q;
		logic [VAL_W-1:0] t1_limit_q;
		logic [VAL_W-1:0] t0_cur;
		logic [VAL_W-1:0] t1_cur;
		coded_tile_t      pending_codes[$];
		int unsigned      errors;

		function new();
			t0_base_q  = T0_BASE_RST;
			t1_base_q  = T1_BASE_RST;
			t1_limit_q = T1_LIMIT_RST;
			t0_cur     = T0_BASE_RST;
			t1_cur     = T1_BASE_RST;
			errors     = 0;
		endfunction

		// Count of bits up to the highest one, zero for zero.
		function logic [BITS_W-1:0] msb_count(logic [VAL_W-1:0] v);
			for (int i = VAL_W - 1; i >= 0; i--) begin
				if (v[i]) begin
					return BITS_W'(i + 1);
				end
			end
			return '0;
		endfunction

		function void apply_reg(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] data);
			case (idx)
				REG_T0_BASE: begin
					t0_base_q = data;
					t0_cur    = data;
				end
				REG_T1_BASE: begin
					t1_base_q = data;
					t1_cur    = data;
				end
				REG_T1_LIMIT: begin
					t1_limit_q = data;
				end
				default: begin
				end
			endcase
		endfunction

		// Code one tile and advance the references the way the block does.
		function void note_tile(logic [VAL_W-1:0] v);
			coded_tile_t      e;
			logic [BITS_W-1:0] span;
			logic [VAL_W-1:0]  reach;
			logic [VAL_W-1:0]  offs;
			logic [BITS_W-1:0] raw_bits;
			e.tile = v;
			e.code = '0;
			e.code.op = OP_RAW;
			if (v == t1_cur && t1_cur < t1_limit_q) begin
				e.code.op = OP_T1;
				t1_cur = t1_cur + 1'b1;
			end else if (v == t0_cur) begin
				e.code.op = OP_T0;
				t0_cur = t0_cur + 1'b1;
			end else begin
				span  = msb_count(t1_cur - t1_base_q);
				reach = VAL_W'((17'd1 << span) - 17'd1);
				offs  = v - t1_base_q;
				if (v >= t1_base_q && offs <= reach) begin
					e.code.op      = OP_DELTA;
					e.code.payload = offs;
					e.code.nbits   = span;
				end else begin
					raw_bits = msb_count(t0_cur);
					// Too long for the current T0 width: flag, leave state alone.
					if (msb_count(v) > raw_bits) begin
						e.code.unreach = 1'b1;
					end else begin
						e.code.payload = v;
						e.code.nbits   = raw_bits;
					end
				end
			end
			pending_codes.push_back(e);
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		task compare_field(string name, logic [VAL_W-1:0] tile, logic [VAL_W-1:0] got,
				logic [VAL_W-1:0] want);
			if (got !== want) begin
				report_mismatch($sformatf("tile %h %s got %h want %h", tile, name, got, want));
			end
		endtask

		task check_code(logic [1:0] op, logic [VAL_W-1:0] pl, logic [BITS_W-1:0] nb,
				logic un);
			coded_tile_t e;
			if (pending_codes.size() == 0) begin
				report_mismatch($sformatf("unexpected result op %h payload %h", op, pl));
			end else begin
				e = pending_codes.pop_front();
				compare_field("op_code", e.tile, VAL_W'(op), VAL_W'(e.code.op));
				compare_field("payload", e.tile, pl, e.code.payload);
				compare_field("payload_bits", e.tile, VAL_W'(nb), VAL_W'(e.code.nbits));
				compare_field("unreachable", e.tile, VAL_W'(un), VAL_W'(e.code.unreach));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [VAL_W-1:0]  tile_value;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        op_code;
	logic [VAL_W-1:0]  payload;
	logic [BITS_W-1:0] payload_bits;
	logic              unreachable;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [VAL_W-1:0]  cfg_data;

	int unsigned tx_gap_pct;
	int unsigned rx_stall_pct;

	tile_code_scoreboard sb = new();

	tile_value_dictionary_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.tile_value   (tile_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.op_code      (op_code),
		.payload      (payload),
		.payload_bits (payload_bits),
		.unreachable  (unreachable),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver: stall at random with the current phase's probability.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	// Result monitor: every transaction on the output side is checked against
	// the oldest predicted code. Inputs here are pre-edge values.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_code(op_code, payload, payload_bits, unreachable);
		end
	end

	// Offer one tile, with random gaps first; hold it until accepted.
	// Valid stays high across back-to-back transactions, so it gets only one
	// assignment per edge.
	task automatic send_tile(input logic [VAL_W-1:0] v);
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid   <= 1'b0;
			tile_value <= VAL_W'($urandom);
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		tile_value <= v;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_tile(v);
	endtask

	// Drain the pipeline: drop valid and wait for every predicted result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_codes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.apply_reg(idx, data);
	endtask

	// Reprogram all registers with the block empty; the spare index gets
	// random data that must be ignored.
	task automatic write_config(input logic [VAL_W-1:0] t0, input logic [VAL_W-1:0] t1,
			input logic [VAL_W-1:0] lim);
		drain();
		write_reg(REG_SPARE, VAL_W'($urandom));
		write_reg(REG_T0_BASE, t0);
		write_reg(REG_T1_BASE, t1);
		write_reg(REG_T1_LIMIT, lim);
		cfg_we <= 1'b0;
	endtask

	// Mostly hit the references and the delta window so the counters keep
	// moving; the rest is small values and full-range noise.
	function automatic logic [VAL_W-1:0] pick_tile();
		int unsigned      roll;
		logic [VAL_W-1:0] t1_gap;
		roll = $urandom_range(99);
		t1_gap = sb.t1_cur - sb.t1_base_q;
		if (roll < 30) begin
			return sb.t1_cur;
		end
		if (roll < 55) begin
			return sb.t0_cur;
		end
		if (roll < 70) begin
			return sb.t1_base_q + VAL_W'($urandom_range(0, 2 * t1_gap + 1));
		end
		if (roll < 80) begin
			return VAL_W'($urandom_range(0, 31));
		end
		return VAL_W'($urandom);
	endfunction

	initial begin
		logic [VAL_W-1:0] t0_pick;
		logic [VAL_W-1:0] t1_pick;
		logic [VAL_W-1:0] lim_pick;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		tile_value   = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_T0_BASE;
		cfg_data     = '0;
		tx_gap_pct   = 21;
		rx_stall_pct = 65;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset references: T1 match, T0 match, unreachable, delta.
		send_tile(16'h0000);
		send_tile(16'h0000);
		send_tile(16'hFFFF);
		send_tile(16'h0001);
		send_tile(16'h0001);
		send_tile(16'h0001);

		// T1 at its limit: zero-bit delta, T0 wrap, unreachable with no T0 width.
		write_config(16'hFFFF, 16'h8000, 16'h8000);
		send_tile(16'h8000);
		send_tile(16'hFFFF);
		send_tile(16'h1234);
		send_tile(16'h0000);
		send_tile(16'h8000);

		// T1 at FFFF, blocked by its limit: zero-bit delta; full-width raw; T0 match.
		write_config(16'h8000, 16'hFFFF, 16'hFFFF);
		send_tile(16'hFFFF);
		send_tile(16'h0000);
		send_tile(16'hABCD);
		send_tile(16'h8000);
		send_tile(16'hFFFF);
		send_tile(16'h7FFF);

		// Limit of zero blocks every T1 match.
		write_config(16'h1234, 16'h0010, 16'h0000);
		send_tile(16'h0010);
		send_tile(16'h1234);
		send_tile(16'h0000);
		send_tile(16'hFFFF);
		send_tile(16'h1FFF);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			t0_pick  = VAL_W'($urandom);
			t1_pick  = VAL_W'($urandom);
			lim_pick = ($urandom_range(1) == 0) ? VAL_W'($urandom) :
				t1_pick + VAL_W'($urandom_range(0, 40));
			case (ph)
				0: write_config(T0_BASE_RST, T1_BASE_RST, T1_LIMIT_RST);
				2: write_config(16'hFFFF, 16'hFFFF, 16'h0000);
				5: write_config(16'h8000, 16'h7FF0, 16'h8000);
				default: write_config(t0_pick, t1_pick, lim_pick);
			endcase
			// Swap the idle pattern every two phases; the last two run flat out.
			if (ph == 2) begin
				tx_gap_pct   = 65;
				rx_stall_pct = 21;
			end else if (ph == 4) begin
				tx_gap_pct   = 0;
				rx_stall_pct = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_tile(pick_tile());
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: a correct run finishes far sooner than this.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### tile_value_dictionary_encoder.f
+incdir+src
src/tvde_pkg.sv
src/tvde_regs.sv
src/tvde_encode.sv
src/tile_value_dictionary_encoder.sv
src/tvde_checker.sv
tb/tb_tile_value_dictionary_encoder.sv
